FILE: hdl/gsu_pkg.sv
// shared types, constants and helpers for the gsm septet unpacker
package gsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] HEADER_RESET = 4'd6;
    localparam logic [6:0] CR_CODE      = 7'h0d;
    localparam logic [2:0] LAST_OFFSET  = 3'd6;
    localparam logic [2:0] SEPTET_BITS  = 3'd7;

    typedef struct packed {
        logic [6:0] character;
        logic       char_present;
        logic       end_of_text;
    } result_t;

    typedef struct packed {
        logic [3:0] header_left;
        logic [2:0] bit_offset;
        logic [6:0] carry_bits;
        logic       text_ended;
    } page_state_t;

    localparam result_t END_MARKER = '{character: 7'd0, char_present: 1'b0, end_of_text: 1'b1};

    function automatic page_state_t restart_state(input logic [3:0] header_octets);
        page_state_t s;
        s.header_left = header_octets;
        s.bit_offset  = 3'd0;
        s.carry_bits  = 7'd0;
        s.text_ended  = 1'b0;
        return s;
    endfunction

endpackage

FILE: hdl/gsm_septet_unpacker.sv
// top level of the gsm septet unpacker
// Takes one octet of a message page per cycle while the result queue has room, and unpacks
// GSM 7-bit characters after header_octets skipped octets (reset 6). Every octet is decoded
// in the cycle it is accepted against the page state registers; results go into a
// four-entry result queue that drains one result per cycle while m_axis_tready is high.
// Every seventh data octet gives two results, so under a continuous stream the output side
// sets the pace; otherwise one octet is taken every cycle. Results are registered in the
// result queue. A write on the cfg channel is taken at once and restarts the page.
module gsm_septet_unpacker #(
    parameter int QUEUE_DEPTH = gsu_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,        // header_octets

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // data_octet[7:0]
    input  logic       s_axis_tlast,    // last_octet

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // character[6:0], zero pad[7]
    output logic       m_axis_tuser,    // char_present
    output logic       m_axis_tlast     // end_of_text
);

    gsu_pkg::page_state_t   state_reg, state_next;
    logic [3:0]             header_octets_reg;
    gsu_pkg::result_t [1:0] results;
    logic [1:0]             result_count;
    logic [1:0]             push_count;
    logic                   in_xfer;
    logic                   cfg_xfer;
    logic                   room;
    gsu_pkg::result_t       head;

    assign cfg_ready     = 1'b1;
    assign cfg_xfer      = cfg_valid && cfg_ready;
    assign s_axis_tready = room;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign push_count    = in_xfer ? result_count : 2'd0;

    gsu_septet_decode u_decode (
        .state         (state_reg),
        .data_octet    (s_axis_tdata),
        .last_octet    (s_axis_tlast),
        .header_octets (header_octets_reg),
        .state_next    (state_next),
        .results       (results),
        .result_count  (result_count)
    );

    gsu_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_data  (results),
        .push_count (push_count),
        .room       (room),
        .head       (head),
        .head_valid (m_axis_tvalid),
        .pop        (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, head.character};
    assign m_axis_tuser = head.char_present;
    assign m_axis_tlast = head.end_of_text;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_octets_reg <= gsu_pkg::HEADER_RESET;
            state_reg         <= gsu_pkg::restart_state(gsu_pkg::HEADER_RESET);
        end else if (cfg_xfer) begin
            header_octets_reg <= cfg_data;
            state_reg         <= gsu_pkg::restart_state(cfg_data);
        end else if (in_xfer) begin
            state_reg <= state_next;
        end
    end

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_xfer && !cfg_xfer) |=> $stable(state_reg))
        else $error("page state changed without transfer");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
        else $error("waiting result changed before transfer");

    a_bare_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
        else $error("result without character is not a bare end marker");

endmodule

FILE: hdl/gsu_septet_decode.sv
// combinational step: one octet against the page state gives up to two results
module gsu_septet_decode (
    input  gsu_pkg::page_state_t        state,
    input  logic [7:0]                  data_octet,
    input  logic                        last_octet,
    input  logic [3:0]                  header_octets,
    output gsu_pkg::page_state_t        state_next,
    output gsu_pkg::result_t [1:0]      results,
    output logic [1:0]                  result_count
);

    logic [14:0] shifted;
    logic [7:0]  high_part;
    logic [6:0] ch;

    always_comb begin
        shifted   = {7'd0, data_octet} << state.bit_offset;
        high_part = data_octet >> (gsu_pkg::SEPTET_BITS - state.bit_offset);
        ch        = shifted[6:0] | state.carry_bits;

        state_next   = state;
        results      = '0;
        result_count = 2'd0;

        if (state.text_ended) begin
            if (last_octet) begin
                state_next = gsu_pkg::restart_state(header_octets);
            end
        end else begin
            if (state.header_left != 4'd0) begin
                state_next.header_left = state.header_left - 4'd1;
            end else if (ch == gsu_pkg::CR_CODE || ch == 7'd0) begin
                results[0]            = gsu_pkg::END_MARKER;
                result_count          = 2'd1;
                state_next.text_ended = 1'b1;
            end else begin
                results[0]   = '{character: ch, char_present: 1'b1, end_of_text: 1'b0};
                result_count = 2'd1;
                if (state.bit_offset == gsu_pkg::LAST_OFFSET) begin
                    // seventh octet: carried septet comes out as its own character, or as an end marker when zero
                    state_next.bit_offset = 3'd0;
                    state_next.carry_bits = 7'd0;
                    result_count          = 2'd2;
                    if (high_part[6:0] == 7'd0) begin
                        results[1]            = gsu_pkg::END_MARKER;
                        state_next.text_ended = 1'b1;
                    end else begin
                        results[1] = '{character: high_part[6:0], char_present: 1'b1,
                                       end_of_text: 1'b0};
                    end
                end else begin
                    state_next.bit_offset = state.bit_offset + 3'd1;
                    state_next.carry_bits = high_part[6:0];
                end
            end

            if (last_octet) begin
                case (result_count)
                    2'd0: begin
                        results[0]   = gsu_pkg::END_MARKER;
                        result_count = 2'd1;
                    end
                    2'd1:    results[0].end_of_text = 1'b1;
                    2'd2:    results[1].end_of_text = 1'b1;
                    default: results[0].end_of_text = 1'b1;
                endcase
                state_next = gsu_pkg::restart_state(header_octets);
            end
        end
    end

endmodule

FILE: hdl/gsu_result_queue.sv
// small result queue: up to two pushes and one pop per cycle
module gsu_result_queue #(
    parameter int DEPTH = gsu_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gsu_pkg::result_t [1:0]  push_data,
    input  logic [1:0]              push_count,
    output logic                    room,
    output gsu_pkg::result_t        head,
    output logic                    head_valid,
    input  logic                    pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gsu_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_second;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign room          = (count_reg <= CNT_W'(DEPTH - 2));
    assign head_valid    = (count_reg != '0);
    assign head          = mem[rd_ptr_reg];
    assign do_pop        = pop && head_valid;
    assign wr_ptr_second = next_ptr(wr_ptr_reg);

    always_comb begin
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_second;
            2'd2:    wr_ptr_next = next_ptr(wr_ptr_second);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = do_pop ? next_ptr(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_data[0];
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_second] <= push_data[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count beyond depth");

    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> room)
        else $error("push into result queue without room");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count == 2'd0 && !do_pop) |=> $stable(count_reg))
        else $error("result queue count moved without transfer");

endmodule
